// ----- hdl/assert_macros.svh -----
// Assertion macros used by the RTL of the escape-time block.
// No dependencies; synthesis builds define SYNTHESIS and get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ----- hdl/mbet_pkg.sv -----
// Package for the Mandelbrot escape-time block: widths, codes, reset values
// and the saturating fixed-point helpers. No dependencies.
`default_nettype none

package mbet_pkg;

  localparam int VALUE_W   = 32;
  localparam int FRAC_W    = 28;
  localparam int ITER_W    = 16;
  localparam int COORD_W   = 12;
  localparam int STEP_W    = 31;
  localparam int GRAY_W    = 8;
  localparam int PROD_W    = 2 * VALUE_W;
  localparam int NUM_W     = ITER_W + GRAY_W;
  localparam int DIVCNT_W  = $clog2(GRAY_W);
  localparam int CFG_IDX_W = 3;
  localparam int IN_W      = ((2 * COORD_W + 7) / 8) * 8;
  localparam int OUT_W     = ((ITER_W + GRAY_W + 7) / 8) * 8;

  typedef logic signed [VALUE_W-1:0] fx_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  localparam fx_t   VMAX   = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam fx_t   VMIN   = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam prod_t VMAX_W = prod_t'(VMAX);
  localparam prod_t VMIN_W = prod_t'(VMIN);
  // Escape threshold 4.0, or the top value when 4.0 does not fit
  localparam fx_t   FOUR   = (FRAC_W + 2 >= VALUE_W - 1) ? VMAX
                             : fx_t'(longint'(4) << FRAC_W);

  // Register reset values
  localparam fx_t               X_ORIGIN_RST = fx_t'(-536870912);
  localparam fx_t               Y_ORIGIN_RST = fx_t'(-536870912);
  localparam logic [STEP_W-1:0] STEP_X_RST   = STEP_W'(786432);
  localparam logic [STEP_W-1:0] STEP_Y_RST   = STEP_W'(1048576);
  localparam logic [ITER_W-1:0] LIMIT_RST    = ITER_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_ORIGIN   = 3'd0,
    CFG_Y_ORIGIN   = 3'd1,
    CFG_STEP_X     = 3'd2,
    CFG_STEP_Y     = 3'd3,
    CFG_ITER_LIMIT = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP_X,
    ST_MAP_Y,
    ST_MAP_C,
    ST_ITER,
    ST_DIV,
    ST_DONE
  } state_e;

  // Steps of one complex iteration on the shared multiplier
  typedef enum logic [1:0] {
    PH_SQ_X,
    PH_SQ_Y,
    PH_CROSS,
    PH_UPDATE
  } phase_e;

  function automatic fx_t sat_add(fx_t a, fx_t b);
    logic signed [VALUE_W:0] s;
    s = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
    if (s[VALUE_W] != s[VALUE_W-1]) return s[VALUE_W] ? VMIN : VMAX;
    return s[VALUE_W-1:0];
  endfunction

  function automatic fx_t sat_sub(fx_t a, fx_t b);
    logic signed [VALUE_W:0] s;
    s = {a[VALUE_W-1], a} - {b[VALUE_W-1], b};
    if (s[VALUE_W] != s[VALUE_W-1]) return s[VALUE_W] ? VMIN : VMAX;
    return s[VALUE_W-1:0];
  endfunction

  // Full product to fixed point: floor shift, then saturate
  function automatic fx_t fx_scale(prod_t p);
    prod_t q;
    q = p >>> FRAC_W;
    if (q > VMAX_W) return VMAX;
    if (q < VMIN_W) return VMIN;
    return q[VALUE_W-1:0];
  endfunction

  // Non-negative integer product (pixel times step), saturated
  function automatic fx_t sat_step(prod_t p);
    if (p > VMAX_W) return VMAX;
    return p[VALUE_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/mandelbrot_escape_time.sv -----
// Mandelbrot escape-time evaluator: maps a pixel to c, iterates z = z^2 + c
// on one shared 32x32 multiplier, then derives a gray level. Uses mbet_pkg.
// Sequence: mapping in ST_MAP_X, ST_MAP_Y and ST_MAP_C, then iterations on the
// shared multiplier in phases PH_SQ_X, PH_SQ_Y, PH_CROSS and PH_UPDATE, with the
// escape check in PH_UPDATE and the limit check in PH_SQ_X, then shift-subtract
// division in ST_DIV and the load of the output register in ST_DONE. One pixel
// in flight at a time; the next pixel is taken the cycle after the result loads
// the output register.
// Reset (async, active low) loads default window and limit 256, clears control.
`default_nettype none

module mandelbrot_escape_time (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Pixel input: [11:0] pixel_column, [23:12] pixel_row
  input  wire logic                                s_axis_tvalid_i,
  output      logic                                s_axis_tready_o,
  input  wire logic [mbet_pkg::IN_W-1:0]           s_axis_tdata_i,
  // Result output: [15:0] iteration_count, [23:16] gray_level
  output      logic                                m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  output      logic [mbet_pkg::OUT_W-1:0]          m_axis_tdata_o,
  // Configuration write port
  input  wire logic                                cfg_we_i,
  input  wire logic [mbet_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [mbet_pkg::VALUE_W-1:0]        cfg_wdata_i
);
  import mbet_pkg::*;

  `include "assert_macros.svh"

  // Configuration registers
  fx_t               x_origin_q, y_origin_q;
  logic [STEP_W-1:0] step_x_q, step_y_q;
  logic [ITER_W-1:0] limit_q;

  // Control
  state_e               state_q, state_d;
  phase_e               phase_q, phase_d;
  logic [DIVCNT_W-1:0]  div_cnt_q, div_cnt_d;
  logic                 out_valid_q, out_valid_d;

  // Datapath
  logic [COORD_W-1:0] col_q, row_q;
  fx_t                cx_q, cy_q, zx_q, zy_q, zx2_q, zy2_q;
  logic [ITER_W-1:0]  count_q;
  prod_t              prod_q;
  logic [NUM_W-1:0]   rem_q, dvs_q;
  logic [GRAY_W-1:0]  quo_q;
  logic [ITER_W-1:0]  out_count_q;
  logic [GRAY_W-1:0]  out_gray_q;

  fx_t   mul_a, mul_b, two_zx;
  prod_t prod_d;
  logic  in_xfer, out_load, lim_hit, escaped, div_start;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign lim_hit  = (count_q == limit_q);
  assign escaped  = (sat_add(zx2_q, zy2_q) > FOUR);
  assign two_zx   = sat_add(zx_q, zx_q);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_origin_q <= X_ORIGIN_RST;
      y_origin_q <= Y_ORIGIN_RST;
      step_x_q   <= STEP_X_RST;
      step_y_q   <= STEP_Y_RST;
      limit_q    <= LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_X_ORIGIN:   x_origin_q <= cfg_wdata_i;
        CFG_Y_ORIGIN:   y_origin_q <= cfg_wdata_i;
        CFG_STEP_X:     step_x_q   <= cfg_wdata_i[STEP_W-1:0];
        CFG_STEP_Y:     step_y_q   <= cfg_wdata_i[STEP_W-1:0];
        CFG_ITER_LIMIT: limit_q    <= cfg_wdata_i[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = zx_q;
    mul_b = zx_q;
    case (state_q)
      ST_MAP_X: begin
        mul_a = fx_t'({{(VALUE_W-COORD_W){1'b0}}, col_q});
        mul_b = fx_t'({{(VALUE_W-STEP_W){1'b0}}, step_x_q});
      end
      ST_MAP_Y: begin
        mul_a = fx_t'({{(VALUE_W-COORD_W){1'b0}}, row_q});
        mul_b = fx_t'({{(VALUE_W-STEP_W){1'b0}}, step_y_q});
      end
      ST_ITER: begin
        case (phase_q)
          PH_SQ_X: begin
            mul_a = zx_q;
            mul_b = zx_q;
          end
          PH_SQ_Y: begin
            mul_a = zy_q;
            mul_b = zy_q;
          end
          default: begin
            mul_a = two_zx;
            mul_b = zy_q;
          end
        endcase
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Next state and sequencing
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    div_cnt_d   = div_cnt_q;
    div_start   = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) out_valid_d = 1'b0;
    s_axis_tready_o = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE:  if (in_xfer) state_d = ST_MAP_X;
      ST_MAP_X: state_d = ST_MAP_Y;
      ST_MAP_Y: state_d = ST_MAP_C;
      ST_MAP_C: begin
        state_d = ST_ITER;
        phase_d = PH_SQ_X;
      end
      ST_ITER: begin
        case (phase_q)
          PH_SQ_X: begin
            if (lim_hit) begin
              div_start = 1'b1;
              state_d   = ST_DIV;
            end else begin
              phase_d = PH_SQ_Y;
            end
          end
          PH_SQ_Y:  phase_d = PH_CROSS;
          PH_CROSS: phase_d = PH_UPDATE;
          default: begin
            if (escaped) begin
              div_start = 1'b1;
              state_d   = ST_DIV;
            end
            phase_d = PH_SQ_X;
          end
        endcase
        if (div_start) div_cnt_d = DIVCNT_W'(GRAY_W - 1);
      end
      ST_DIV: begin
        div_cnt_d = div_cnt_q - 1'b1;
        if (div_cnt_q == '0) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_SQ_X;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (in_xfer) begin
      col_q   <= s_axis_tdata_i[COORD_W-1:0];
      row_q   <= s_axis_tdata_i[2*COORD_W-1:COORD_W];
      zx_q    <= '0;
      zy_q    <= '0;
      count_q <= '0;
    end
    if (state_q == ST_MAP_Y) cx_q <= sat_add(x_origin_q, sat_step(prod_q));
    if (state_q == ST_MAP_C) cy_q <= sat_add(y_origin_q, sat_step(prod_q));
    if (state_q == ST_ITER) begin
      case (phase_q)
        PH_SQ_Y:  zx2_q <= fx_scale(prod_q);
        PH_CROSS: zy2_q <= fx_scale(prod_q);
        PH_UPDATE: begin
          if (!escaped) begin
            zx_q    <= sat_add(sat_sub(zx2_q, zy2_q), cx_q);
            zy_q    <= sat_add(fx_scale(prod_q), cy_q);
            count_q <= count_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
    // Gray level: 255*count / limit, one quotient bit per cycle
    if (div_start) begin
      rem_q <= {count_q, {GRAY_W{1'b0}}} - {{GRAY_W{1'b0}}, count_q};
      dvs_q <= {1'b0, limit_q, {(GRAY_W-1){1'b0}}};
      quo_q <= '0;
    end else if (state_q == ST_DIV) begin
      if (rem_q >= dvs_q) begin
        rem_q <= rem_q - dvs_q;
        quo_q <= {quo_q[GRAY_W-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[GRAY_W-2:0], 1'b0};
      end
      dvs_q <= dvs_q >> 1;
    end
    if (out_load) begin
      out_count_q <= count_q;
      out_gray_q  <= (limit_q == '0) ? '0 : quo_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_W'({out_gray_q, out_count_q});

  // Checks
  `ASSERT_CLK(a_count_bound, clk_i, rst_ni, (state_q == ST_ITER) |-> (count_q <= limit_q))
  `ASSERT_CLK(a_gray_zero, clk_i, rst_ni, (out_valid_q && out_count_q == '0) |-> (out_gray_q == '0))
  `ASSERT_CLK(a_gray_full, clk_i, rst_ni, (out_valid_q && out_count_q == limit_q && limit_q != '0) |-> (out_gray_q == {GRAY_W{1'b1}}))
  `ASSERT_NEVER(a_div_overrun, clk_i, rst_ni, (state_q == ST_DONE) && $past(state_q == ST_DIV) && ($past(div_cnt_q) != '0))

endmodule

`default_nettype wire
